### rtl/brfb_pkg.sv
`default_nettype none

package brfb_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;
  localparam logic [1:0] ACT_HEADER = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] SIZE_LOG2_RESET = 3'd6;

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic multi;
    logic rd_more;
  } stat_t;

endpackage

`default_nettype wire

### rtl/brfb_ram.sv
`default_nettype none

module brfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/brfb_ctrl.sv
`default_nettype none

module brfb_ctrl
  import brfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && slot_free && stat.multi) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (slot_free && !stat.rd_more) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = slot_free;
        cmd.take     = slot_free && in_valid;
        cmd.rd_issue = slot_free && in_valid && stat.multi;
      end
      S_READ: begin
        cmd.emit     = slot_free;
        cmd.rd_issue = slot_free && stat.rd_more;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/brfb_dp.sv
`default_nettype none

module brfb_dp
  import brfb_pkg::*;
#(
  parameter int ADDR_BITS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,
  input  wire logic [1:0] action,
  input  wire logic [7:0] data_byte,
  input  wire logic [5:0] burst_length,
  input  wire logic       out_ready,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  output logic [1:0]      status,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last,
  output logic [5:0]      fill_level,
  output logic [5:0]      free_room
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [2:0]           size_log2;
  logic [2:0]           lg_eff;
  logic [ADDR_BITS-1:0] mask;

  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS-1:0] rp;
  logic [ADDR_BITS-1:0] wp_next;
  logic [ADDR_BITS-1:0] rp_next;
  logic [5:0]           brem;
  logic [5:0]           brem_next;
  logic                 bref;
  logic                 bref_next;

  logic [ADDR_BITS-1:0] fill;
  logic [ADDR_BITS-1:0] room;
  logic [ADDR_BITS-1:0] fill_next;
  logic [ADDR_BITS-1:0] room_next;
  logic                 full;
  logic                 store_ok;
  logic                 multi;
  logic [1:0]           st;

  logic [5:0]           cnt;
  logic [ADDR_BITS-1:0] rd_ptr;
  logic [ADDR_BITS-1:0] issue_addr;
  logic [7:0]           rdata;
  logic                 out_valid;

  always_comb begin
    if (size_log2 == 3'd0) begin
      lg_eff = 3'd1;
    end else if (size_log2 > 3'(ADDR_BITS)) begin
      lg_eff = 3'(ADDR_BITS);
    end else begin
      lg_eff = size_log2;
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      mask[i] = (i < int'(lg_eff));
    end
  end

  assign fill = (wp - rp) & mask;
  assign room = mask - fill;
  assign full = ((wp + ADDR_BITS'(1)) & mask) == rp;

  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    brem_next = brem;
    bref_next = bref;
    st        = ST_OK;
    store_ok  = 1'b0;
    multi     = 1'b0;
    unique case (action) inside
      ACT_WRITE: begin
        if (brem != 6'd0) begin
          brem_next = brem - 6'd1;
          if (bref || full) begin
            st = ST_FULL;
          end else begin
            store_ok = 1'b1;
          end
          if (brem == 6'd1) begin
            bref_next = 1'b0;
          end
        end else if (full) begin
          st = ST_FULL;
        end else begin
          store_ok = 1'b1;
        end
        if (store_ok) begin
          wp_next = (wp + ADDR_BITS'(1)) & mask;
        end
      end
      ACT_HEADER: begin
        if (burst_length > 6'(room)) begin
          bref_next = 1'b1;
          st        = ST_FULL;
        end else begin
          bref_next = 1'b0;
        end
        brem_next = burst_length;
      end
      ACT_READ, ACT_PEEK: begin
        if (burst_length > 6'(fill)) begin
          st = ST_EMPTY;
        end else if (burst_length != 6'd0) begin
          multi = 1'b1;
          if (action == ACT_READ) begin
            rp_next = (rp + burst_length[ADDR_BITS-1:0]) & mask;
          end
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign fill_next = (wp_next - rp_next) & mask;
  assign room_next = mask - fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_LOG2_RESET;
      wp        <= '0;
      rp        <= '0;
      brem      <= '0;
      bref      <= 1'b0;
    end else if (cfg_wr_en) begin
      size_log2 <= cfg_wr_data;
      wp        <= '0;
      rp        <= '0;
      brem      <= '0;
      bref      <= 1'b0;
    end else if (cmd.take) begin
      wp   <= wp_next;
      rp   <= rp_next;
      brem <= brem_next;
      bref <= bref_next;
    end
  end

  assign issue_addr = cmd.take ? rp : rd_ptr;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_ptr <= (issue_addr + ADDR_BITS'(1)) & mask;
    end
    if (cmd.take && multi) begin
      cnt <= burst_length;
    end else if (cmd.emit) begin
      cnt <= cnt - 6'd1;
    end
  end

  brfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.take && store_ok),
    .waddr (wp),
    .wdata (data_byte),
    .re    (cmd.rd_issue),
    .raddr (issue_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take && !multi) || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !multi) begin
      status     <= st;
      out_byte   <= 8'd0;
      byte_valid <= 1'b0;
      last       <= 1'b1;
      fill_level <= 6'(fill_next);
      free_room  <= 6'(room_next);
    end else if (cmd.emit) begin
      status     <= ST_OK;
      out_byte   <= rdata;
      byte_valid <= 1'b1;
      last       <= (cnt == 6'd1);
      fill_level <= 6'(fill);
      free_room  <= 6'(room);
    end
  end

  assign stat.out_valid = out_valid;
  assign stat.multi     = multi;
  assign stat.rd_more   = (cnt != 6'd1);

endmodule

`default_nettype wire

### rtl/byte_ring_fifo_with_bursts_unit.sv
// Byte FIFO in a power-of-two ring with burst-write reservation.
// Input words arrive on s_axis: tuser carries the action (write, read, peek,
// burst header), tdata carries the data byte and the length. Result words
// leave on m_axis with tlast on the final result of each input word and
// tuser set when tdata carries a byte taken from the ring.
// A write, a burst header, or a read or peek that returns no byte gives one
// result in the cycle after acceptance, and the next word may be accepted in
// that same cycle, so these run at one word per cycle while the receiver is ready.
// A read or peek of N bytes passes its first byte through the registered read
// port of the ring memory and then the result register, then gives one byte per
// cycle, the pace of that read port, while the receiver is ready; no new input
// word is taken until the last byte is loaded.
// When the receiver stalls, the result register holds and input is held off.
// Reset empties the ring, cancels any burst and sets the size to 64 bytes.
// A write of cfg_wr_data sets log2 of the ring size and empties the ring.
`default_nettype none

module byte_ring_fifo_with_bursts_unit
  import brfb_pkg::*;
#(
  parameter int ADDR_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], burst_length[13:8], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // status[1:0], out_byte[9:2], fill_level[15:10],
                                          // free_room[21:16], zero pad
  output logic [0:0]       m_axis_tuser,  // byte_valid[0]
  output logic             m_axis_tlast
);

  cmd_t       cmd;
  stat_t      stat;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [5:0] fill_level;
  logic [5:0] free_room;

  brfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brfb_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .action       (s_axis_tuser),
    .data_byte    (s_axis_tdata[7:0]),
    .burst_length (s_axis_tdata[13:8]),
    .out_ready    (m_axis_tready),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (m_axis_tlast),
    .fill_level   (fill_level),
    .free_room    (free_room)
  );

  assign m_axis_tvalid   = stat.out_valid;
  assign m_axis_tuser[0] = byte_valid;
  assign m_axis_tdata    = {2'b00, free_room, fill_level, out_byte, status};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("pending result before new input is not a final result");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[1:0] == ST_OK)
    else $error("byte result with nonzero status");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[9:2] == 8'd0)
    else $error("non-byte result not single or carries data");
`endif

endmodule

`default_nettype wire
